// File: hw/rtl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg
// shared types and constants of the hsv to rgb pixel writer pipeline
// ----------------------------------------------------------------------------
package hsv_pkg;

  // number of leds on the strip, indices at or above this are dropped
  localparam logic [7:0] LED_COUNT = 8'd90;

  localparam logic [8:0] HUE_MAX     = 9'd359;
  localparam logic [9:0] HUE_LIMIT   = 10'd360;
  localparam logic [5:0] FRAC_TOP    = 6'd59;
  localparam logic [7:0] LEVEL_FULL  = 8'd255;

  // floor(y/15) == (y*RECIP_15) >> RECIP_SHIFT for y < 2^12
  localparam logic [15:0] RECIP_15    = 16'd34953;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW  = 3'd0,
    SEC_YELLOW_GRN  = 3'd1,
    SEC_GRN_CYAN    = 3'd2,
    SEC_CYAN_BLUE   = 3'd3,
    SEC_BLUE_MAG    = 3'd4,
    SEC_MAG_RED     = 3'd5
  } sector_e;

  // sideband that travels with each beat through the pipeline
  typedef struct packed {
    logic [7:0] led_index;
    logic       in_range;
    logic       grey;
    sector_e    sector;
    logic [7:0] val;
  } pix_ctl_t;

endpackage

// File: hw/rtl/hsv_front.sv
// ----------------------------------------------------------------------------
// hsv_front
// first stage: led index, range check, hue clamp and sector split
// ----------------------------------------------------------------------------
module hsv_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  logic [4:0]        column_i,
  input  logic [2:0]        row_i,
  input  logic [9:0]        hue_i,
  input  logic [7:0]        saturation_i,
  input  logic [7:0]        brightness_i,
  output logic              valid_o,
  output hsv_pkg::pix_ctl_t ctl_o,
  output logic [5:0]        frac_o,
  output logic [7:0]        sat_o
);

  logic              valid_q;
  hsv_pkg::pix_ctl_t ctl_d, ctl_q;
  logic [5:0]        frac_d, frac_q;
  logic [7:0]        sat_q;
  logic [8:0]        hue_c;
  logic [8:0]        base;
  logic [8:0]        frac_w;
  hsv_pkg::sector_e  sector;

  always_comb begin
    hue_c = (hue_i >= hsv_pkg::HUE_LIMIT) ? hsv_pkg::HUE_MAX : hue_i[8:0];
    priority if (hue_c >= 9'd300) begin
      sector = hsv_pkg::SEC_MAG_RED;
      base   = 9'd300;
    end else if (hue_c >= 9'd240) begin
      sector = hsv_pkg::SEC_BLUE_MAG;
      base   = 9'd240;
    end else if (hue_c >= 9'd180) begin
      sector = hsv_pkg::SEC_CYAN_BLUE;
      base   = 9'd180;
    end else if (hue_c >= 9'd120) begin
      sector = hsv_pkg::SEC_GRN_CYAN;
      base   = 9'd120;
    end else if (hue_c >= 9'd60) begin
      sector = hsv_pkg::SEC_YELLOW_GRN;
      base   = 9'd60;
    end else begin
      sector = hsv_pkg::SEC_RED_YELLOW;
      base   = 9'd0;
    end
    frac_w = hue_c - base;
    frac_d = frac_w[5:0];

    // 6*column + row, at most 193 so 8 bits never wrap
    ctl_d.led_index = {1'b0, column_i, 2'b00} + {2'b00, column_i, 1'b0} + {5'd0, row_i};
    ctl_d.in_range  = (ctl_d.led_index < hsv_pkg::LED_COUNT);
    ctl_d.grey      = (saturation_i == 8'd0);
    ctl_d.sector    = sector;
    ctl_d.val       = brightness_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctl_q  <= ctl_d;
      frac_q <= frac_d;
      sat_q  <= saturation_i;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign frac_o  = frac_q;
  assign sat_o   = sat_q;

endmodule

// File: hw/rtl/hsv_level.sv
// ----------------------------------------------------------------------------
// hsv_level
// three stages computing the p, q and t levels from v, s and the hue remainder
// ----------------------------------------------------------------------------
module hsv_level (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  hsv_pkg::pix_ctl_t ctl_i,
  input  logic [5:0]        frac_i,
  input  logic [7:0]        sat_i,
  output logic              valid_o,
  output hsv_pkg::pix_ctl_t ctl_o,
  output logic [7:0]        p_o,
  output logic [7:0]        q_o,
  output logic [7:0]        t_o
);

  // stage a: products s*f, s*(59-f) and the p level
  logic              a_valid_q;
  hsv_pkg::pix_ctl_t a_ctl_q;
  logic [13:0]       a_prod_q_d, a_prod_q_q;
  logic [13:0]       a_prod_t_d, a_prod_t_q;
  logic [15:0]       a_p_full;
  logic [7:0]        a_p_q;
  logic [5:0]        frac_inv;

  // stage b: divide both products by 60
  logic              b_valid_q;
  hsv_pkg::pix_ctl_t b_ctl_q;
  logic [27:0]       b_mul_q, b_mul_t;
  logic [7:0]        b_qd_q, b_td_q, b_p_q;

  // stage c: scale v by 255 minus each quotient
  logic              c_valid_q;
  hsv_pkg::pix_ctl_t c_ctl_q;
  logic [15:0]       c_q_full, c_t_full;
  logic [7:0]        c_p_q, c_q_q, c_t_q;

  always_comb begin
    frac_inv   = hsv_pkg::FRAC_TOP - frac_i;
    a_prod_q_d = {6'd0, sat_i} * {8'd0, frac_i};
    a_prod_t_d = {6'd0, sat_i} * {8'd0, frac_inv};
    a_p_full   = {8'd0, ctl_i.val} * {8'd0, (hsv_pkg::LEVEL_FULL - sat_i)};
  end

  // x/60 as (x/4)/15, the quotient is at most 250
  always_comb begin
    b_mul_q = {16'd0, a_prod_q_q[13:2]} * {12'd0, hsv_pkg::RECIP_15};
    b_mul_t = {16'd0, a_prod_t_q[13:2]} * {12'd0, hsv_pkg::RECIP_15};
  end

  always_comb begin
    c_q_full = {8'd0, b_ctl_q.val} * {8'd0, (hsv_pkg::LEVEL_FULL - b_qd_q)};
    c_t_full = {8'd0, b_ctl_q.val} * {8'd0, (hsv_pkg::LEVEL_FULL - b_td_q)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_ctl_q    <= ctl_i;
      a_prod_q_q <= a_prod_q_d;
      a_prod_t_q <= a_prod_t_d;
      a_p_q      <= a_p_full[15:8];

      b_ctl_q    <= a_ctl_q;
      b_qd_q     <= b_mul_q[hsv_pkg::RECIP_SHIFT +: 8];
      b_td_q     <= b_mul_t[hsv_pkg::RECIP_SHIFT +: 8];
      b_p_q      <= a_p_q;

      c_ctl_q    <= b_ctl_q;
      c_p_q      <= b_p_q;
      c_q_q      <= c_q_full[15:8];
      c_t_q      <= c_t_full[15:8];
    end
  end

  assign valid_o = c_valid_q;
  assign ctl_o   = c_ctl_q;
  assign p_o     = c_p_q;
  assign q_o     = c_q_q;
  assign t_o     = c_t_q;

endmodule

// File: hw/rtl/hsv_to_rgb_pixel_writer.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_writer
// converts a matrix coordinate and an hsv color into an led index and rgb
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  --------------------------------
//  in        sink       in_valid_i/in_stall_o  column, row, hue, saturation,
//                                              brightness
//  out       source     out_valid_o/out_stall_i led_index, in_range, red,
//                                              green, blue
//
//  one beat per cycle while not stalled, five register stages from input to output beat
//  the pipeline moves as a whole whenever the output register is empty or taken
//  the stall toward the input is the only path from out_stall_i, there is no
//  combinational path from in_valid_i to out_valid_o
//  reset clears the valid bits of all five stages, the payload is not reset
//
module hsv_to_rgb_pixel_writer (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [4:0] column_i,
  input  logic [2:0] row_i,
  input  logic [9:0] hue_i,
  input  logic [7:0] saturation_i,
  input  logic [7:0] brightness_i,

  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] led_index_o,
  output logic       in_range_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);

  // global advance: the output register is free or its beat leaves now
  logic              adv;

  logic              f_valid;
  hsv_pkg::pix_ctl_t f_ctl;
  logic [5:0]        f_frac;
  logic [7:0]        f_sat;

  logic              l_valid;
  hsv_pkg::pix_ctl_t l_ctl;
  logic [7:0]        l_p, l_q, l_t;

  logic              out_valid_q;
  logic [7:0]        led_index_d, led_index_q;
  logic              in_range_d, in_range_q;
  logic [7:0]        red_d, red_q;
  logic [7:0]        green_d, green_q;
  logic [7:0]        blue_d, blue_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // stage 1: index, range and sector
  hsv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (in_valid_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .valid_o      (f_valid),
    .ctl_o        (f_ctl),
    .frac_o       (f_frac),
    .sat_o        (f_sat)
  );

  // stages 2 to 4: p, q and t levels
  hsv_level u_level (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (f_valid),
    .ctl_i   (f_ctl),
    .frac_i  (f_frac),
    .sat_i   (f_sat),
    .valid_o (l_valid),
    .ctl_o   (l_ctl),
    .p_o     (l_p),
    .q_o     (l_q),
    .t_o     (l_t)
  );

  // stage 5: six-sector placement, grey bypass and out-of-range zeroing
  always_comb begin
    red_d   = l_ctl.val;
    green_d = l_ctl.val;
    blue_d  = l_ctl.val;
    if (!l_ctl.grey) begin
      unique case (l_ctl.sector)
        hsv_pkg::SEC_RED_YELLOW: begin
          red_d = l_ctl.val; green_d = l_t;       blue_d = l_p;
        end
        hsv_pkg::SEC_YELLOW_GRN: begin
          red_d = l_q;       green_d = l_ctl.val; blue_d = l_p;
        end
        hsv_pkg::SEC_GRN_CYAN: begin
          red_d = l_p;       green_d = l_ctl.val; blue_d = l_t;
        end
        hsv_pkg::SEC_CYAN_BLUE: begin
          red_d = l_p;       green_d = l_q;       blue_d = l_ctl.val;
        end
        hsv_pkg::SEC_BLUE_MAG: begin
          red_d = l_t;       green_d = l_p;       blue_d = l_ctl.val;
        end
        default: begin
          red_d = l_ctl.val; green_d = l_p;       blue_d = l_q;
        end
      endcase
    end
    led_index_d = l_ctl.led_index;
    in_range_d  = l_ctl.in_range;
    // dropped pixel: everything reads zero
    if (!l_ctl.in_range) begin
      led_index_d = 8'd0;
      red_d       = 8'd0;
      green_d     = 8'd0;
      blue_d      = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= l_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      led_index_q <= led_index_d;
      in_range_q  <= in_range_d;
      red_q       <= red_d;
      green_q     <= green_d;
      blue_q      <= blue_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_index_o = led_index_q;
  assign in_range_o  = in_range_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  // a dropped pixel carries an all-zero beat
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |->
      led_index_o == 8'd0 && red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0)
    else $error("dropped pixel with nonzero payload");

  // a kept pixel has an index below the led count
  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_range_o |-> led_index_o < hsv_pkg::LED_COUNT)
    else $error("in-range pixel with index beyond led count");

  // input is never held off while the output drains
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output free");

  // a beat held at the output keeps the whole pipeline frozen
  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(l_valid) && $stable(f_valid))
    else $error("pipeline moved during output stall");

endmodule

// File: verif/tb_hsv_to_rgb_pixel_writer.sv
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_pixel_writer
// self-checking bench for the hsv to rgb pixel writer: a short table of
// directed pixels, then a long random stream, each output beat compared field
// by field against its table row or an in-bench six-sector model, with
// random gaps on the input side and random stalls on the output side
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_pixel_writer;

  // run length and safety net
  localparam int RANDOM_PIXELS = 450;
  localparam int CYCLE_LIMIT   = 100000;
  // pipeline is five deep, give it a little more before calling it drained
  localparam int TAIL_CYCLES   = 12;

  // one input beat
  typedef struct packed {
    logic [4:0] column;
    logic [2:0] row;
    logic [9:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } pixel_beat_t;

  // one output beat
  typedef struct packed {
    logic [7:0] led_index;
    logic       in_range;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_beat_t;

  // directed table row, the expected beat is only used when known is set
  typedef struct packed {
    pixel_beat_t px;
    logic        known;
    rgb_beat_t   want;
  } directed_row_t;

  // extremes, boundaries, every sector, clamped hues, grey and dropped pixels
  localparam directed_row_t DIRECTED_ROWS [23] = '{
    // black at the first led
    '{'{5'd0,  3'd0, 10'd0,    8'd0,   8'd0  }, 1'b1, '{8'd0,  1'b1, 8'd0,   8'd0,   8'd0  }},
    // grey at full brightness
    '{'{5'd0,  3'd0, 10'd0,    8'd0,   8'd255}, 1'b1, '{8'd0,  1'b1, 8'd255, 8'd255, 8'd255}},
    // last led on the strip, grey
    '{'{5'd14, 3'd5, 10'd200,  8'd0,   8'd128}, 1'b1, '{8'd89, 1'b1, 8'd128, 8'd128, 8'd128}},
    // first index past the strip
    '{'{5'd15, 3'd0, 10'd120,  8'd255, 8'd255}, 1'b1, '0},
    // largest index and largest hue, dropped
    '{'{5'd31, 3'd7, 10'd1023, 8'd255, 8'd255}, 1'b1, '0},
    // zero brightness gives black whatever the hue
    '{'{5'd2,  3'd3, 10'd300,  8'd255, 8'd0  }, 1'b1, '{8'd15, 1'b1, 8'd0,   8'd0,   8'd0  }},
    // index 90 from a row step, dropped
    '{'{5'd14, 3'd6, 10'd45,   8'd10,  8'd10 }, 1'b1, '0},
    // grey wins over a hue that would clamp
    '{'{5'd3,  3'd7, 10'd600,  8'd0,   8'd77 }, 1'b1, '{8'd25, 1'b1, 8'd77,  8'd77,  8'd77 }},
    // sector starts, middles and ends, checked by the model
    '{'{5'd0,  3'd1, 10'd0,    8'd255, 8'd255}, 1'b0, '0},
    '{'{5'd1,  3'd0, 10'd30,   8'd200, 8'd200}, 1'b0, '0},
    '{'{5'd1,  3'd7, 10'd59,   8'd255, 8'd255}, 1'b0, '0},
    '{'{5'd4,  3'd4, 10'd60,   8'd255, 8'd255}, 1'b0, '0},
    '{'{5'd5,  3'd1, 10'd90,   8'd128, 8'd255}, 1'b0, '0},
    '{'{5'd6,  3'd2, 10'd150,  8'd255, 8'd100}, 1'b0, '0},
    '{'{5'd7,  3'd3, 10'd210,  8'd64,  8'd255}, 1'b0, '0},
    '{'{5'd8,  3'd5, 10'd270,  8'd255, 8'd255}, 1'b0, '0},
    '{'{5'd9,  3'd0, 10'd330,  8'd1,   8'd255}, 1'b0, '0},
    '{'{5'd11, 3'd1, 10'd359,  8'd255, 8'd255}, 1'b0, '0},
    // hue just past the top, and far past it, clamp to 359
    '{'{5'd12, 3'd2, 10'd360,  8'd255, 8'd255}, 1'b0, '0},
    '{'{5'd5,  3'd2, 10'd1023, 8'd170, 8'd85 }, 1'b0, '0},
    '{'{5'd9,  3'd6, 10'd512,  8'd255, 8'd255}, 1'b0, '0},
    // faintest color
    '{'{5'd13, 3'd4, 10'd180,  8'd1,   8'd1  }, 1'b0, '0},
    '{'{5'd10, 3'd2, 10'd240,  8'd255, 8'd255}, 1'b0, '0}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;

  logic       in_valid_i;
  logic       in_stall_o;
  logic [4:0] column_i;
  logic [2:0] row_i;
  logic [9:0] hue_i;
  logic [7:0] saturation_i;
  logic [7:0] brightness_i;

  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] led_index_o;
  logic       in_range_o;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [7:0] blue_o;

  // expected output beats, oldest first
  rgb_beat_t pending_rgb[$];

  int err_count      = 0;
  int pixels_sent    = 0;
  int beats_checked  = 0;
  int off_strip_seen = 0;
  int clamped_sent   = 0;
  int cycle_count    = 0;

  // when set, that side never idles, which gives back-to-back stretches
  bit sender_quiet   = 1'b0;
  bit receiver_quiet = 1'b0;

  hsv_to_rgb_pixel_writer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .column_i     (column_i),
    .row_i        (row_i),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .led_index_o  (led_index_o),
    .in_range_o   (in_range_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  always #2 clk_i = ~clk_i;

  // watchdog, a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d beats still expected",
               $time, cycle_count, pending_rgb.size());
      $display("tb_hsv_to_rgb_pixel_writer failed");
      $finish;
    end
  end

  // in-bench model of the conversion: index check, grey shortcut, hue clamp,
  // then p, q and t placed by sector
  function automatic rgb_beat_t convert_pixel(input pixel_beat_t px);
    rgb_beat_t        o;
    int unsigned      idx, hue, v, s, frac, p, q, t;
    hsv_pkg::sector_e sec;
    o   = '0;
    idx = 6 * px.column + px.row;
    // off the strip, everything reads zero
    if (idx >= hsv_pkg::LED_COUNT) return o;
    v           = px.brightness;
    s           = px.saturation;
    o.led_index = 8'(idx);
    o.in_range  = 1'b1;
    if (s == 0) begin
      o.red   = 8'(v);
      o.green = 8'(v);
      o.blue  = 8'(v);
      return o;
    end
    hue  = (px.hue >= hsv_pkg::HUE_LIMIT) ? hsv_pkg::HUE_MAX : px.hue;
    sec  = hsv_pkg::sector_e'(hue / 60);
    frac = hue % 60;
    // all truncating divisions
    p = v * (255 - s) / 256;
    q = v * (255 - s * frac / 60) / 256;
    t = v * (255 - s * (59 - frac) / 60) / 256;
    case (sec)
      hsv_pkg::SEC_RED_YELLOW: begin o.red = 8'(v); o.green = 8'(t); o.blue = 8'(p); end
      hsv_pkg::SEC_YELLOW_GRN: begin o.red = 8'(q); o.green = 8'(v); o.blue = 8'(p); end
      hsv_pkg::SEC_GRN_CYAN:   begin o.red = 8'(p); o.green = 8'(v); o.blue = 8'(t); end
      hsv_pkg::SEC_CYAN_BLUE:  begin o.red = 8'(p); o.green = 8'(q); o.blue = 8'(v); end
      hsv_pkg::SEC_BLUE_MAG:   begin o.red = 8'(t); o.green = 8'(p); o.blue = 8'(v); end
      default:                 begin o.red = 8'(v); o.green = 8'(p); o.blue = 8'(q); end
    endcase
    return o;
  endfunction

  // random pixel, mostly on the strip with in-range hues, plus some
  // off-strip columns, clamped hues, sector edges and grey
  function automatic pixel_beat_t random_pixel();
    pixel_beat_t px;
    px.row = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) px.column = 5'($urandom_range(0, 31));
    else                           px.column = 5'($urandom_range(0, 14));
    case ($urandom_range(0, 9))
      0:       px.hue = 10'($urandom_range(360, 1023));
      1:       px.hue = 10'(60 * $urandom_range(0, 5) + ($urandom_range(0, 1) ? 59 : 0));
      default: px.hue = 10'($urandom_range(0, 359));
    endcase
    if ($urandom_range(0, 7) == 0) px.saturation = 8'd0;
    else                           px.saturation = 8'($urandom_range(0, 255));
    px.brightness = 8'($urandom_range(0, 255));
    return px;
  endfunction

  // drive one input beat after a random gap, starting and ending at a
  // falling edge; valid stays high into the next beat when that gap is zero
  task automatic send_pixel(input pixel_beat_t px, input bit known, input rgb_beat_t want);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    column_i     <= px.column;
    row_i        <= px.row;
    hue_i        <= px.hue;
    saturation_i <= px.saturation;
    brightness_i <= px.brightness;
    // beat taken at the first rising edge with stall low
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_rgb.push_back(known ? want : convert_pixel(px));
    pixels_sent++;
    if (px.hue >= hsv_pkg::HUE_LIMIT) clamped_sent++;
    @(negedge clk_i);
  endtask

  // drop valid and hold off until every expected beat has come back
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_rgb.size() != 0);
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // output side: random stall before each beat, then compare what arrives
  initial begin : rgb_sink
    int        hold;
    rgb_beat_t want;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = receiver_quiet ? 0 : $urandom_range(0, 7);
      repeat (hold) begin
        out_stall_i <= 1'b1;
        @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      // stall is low here, so a high valid at the edge is a taken beat
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (pending_rgb.size() == 0) begin
        err_count++;
        $display("%0t: output beat with nothing expected, index %0d", $time, led_index_o);
      end else begin
        want = pending_rgb.pop_front();
        check_field("led_index", want.led_index, led_index_o);
        check_field("in_range",  {7'd0, want.in_range}, {7'd0, in_range_o});
        check_field("red",       want.red,       red_o);
        check_field("green",     want.green,     green_o);
        check_field("blue",      want.blue,      blue_o);
        beats_checked++;
        if (!want.in_range) off_strip_seen++;
      end
      @(negedge clk_i);
    end
  end

  // stimulus: reset, directed table, random stream in phases, drain, verdict
  initial begin : pixel_source
    in_valid_i   = 1'b0;
    column_i     = '0;
    row_i        = '0;
    hue_i        = '0;
    saturation_i = '0;
    brightness_i = '0;
    rst_ni       = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    foreach (DIRECTED_ROWS[i])
      send_pixel(DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);
    drain_pipeline();

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      // every 60 pixels pick who idles: both, one side, or neither
      if (n % 60 == 0) begin
        sender_quiet   = $urandom_range(0, 1);
        receiver_quiet = $urandom_range(0, 1);
      end
      // halfway through, let the pipeline run empty once
      if (n == RANDOM_PIXELS / 2) drain_pipeline();
      send_pixel(random_pixel(), 1'b0, '0);
    end

    drain_pipeline();
    // give a stray extra beat time to show up
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("run covered %0d pixels, %0d beats checked, %0d off the strip, %0d clamped hues",
             pixels_sent, beats_checked, off_strip_seen, clamped_sent);
    if (err_count == 0) begin
      $display("tb_hsv_to_rgb_pixel_writer passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("tb_hsv_to_rgb_pixel_writer failed");
    end
    $finish;
  end

endmodule
